// ===== sv/ipidd_pkg.sv =====
package ipidd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int COEF_W     = 24;
  localparam int LIMIT_W    = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = COEF_W + ERR_W;
  // three products plus the accumulator need two guard bits
  localparam int SUM_W      = ACC_W + 2;

  // Configuration bus
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  // Accumulator saturation bounds
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Register map, word index
  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_NOW   = 3'd0,
    REG_COEF_PREV  = 3'd1,
    REG_COEF_PREV2 = 3'd2,
    REG_DEADBAND   = 3'd3,
    REG_UPPER      = 3'd4,
    REG_LOWER      = 3'd5,
    REG_REVERSE    = 3'd6
  } reg_idx_t;

  // Item commands
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef_now;
    logic signed [COEF_W-1:0]  coef_prev;
    logic signed [COEF_W-1:0]  coef_prev2;
    logic        [SAMPLE_W-1:0] deadband;
    logic signed [LIMIT_W-1:0] upper_limit;
    logic signed [LIMIT_W-1:0] lower_limit;
    logic                      reverse_action;
  } cfg_t;

  typedef struct packed {
    cmd_t                       command;
    logic signed [SAMPLE_W-1:0] process_value;
    logic signed [SAMPLE_W-1:0] setpoint;
  } in_item_t;

  typedef struct packed {
    logic signed [LIMIT_W-1:0] drive;
    logic                      in_deadband;
  } result_t;

endpackage

// ===== sv/ipidd_cfg.sv =====
module ipidd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipidd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ipidd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ipidd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output ipidd_pkg::cfg_t                     cfg
);
  import ipidd_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_COEF_NOW:   cfg.coef_now       <= pwdata[COEF_W-1:0];
        REG_COEF_PREV:  cfg.coef_prev      <= pwdata[COEF_W-1:0];
        REG_COEF_PREV2: cfg.coef_prev2     <= pwdata[COEF_W-1:0];
        REG_DEADBAND:   cfg.deadband       <= pwdata[SAMPLE_W-1:0];
        REG_UPPER:      cfg.upper_limit    <= pwdata[LIMIT_W-1:0];
        REG_LOWER:      cfg.lower_limit    <= pwdata[LIMIT_W-1:0];
        REG_REVERSE:    cfg.reverse_action <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Readback, signed registers sign-extended
  always_comb begin
    unique case (idx)
      REG_COEF_NOW:   prdata = CFG_DATA_W'(cfg.coef_now);
      REG_COEF_PREV:  prdata = CFG_DATA_W'(cfg.coef_prev);
      REG_COEF_PREV2: prdata = CFG_DATA_W'(cfg.coef_prev2);
      REG_DEADBAND:   prdata = CFG_DATA_W'(cfg.deadband);
      REG_UPPER:      prdata = CFG_DATA_W'(cfg.upper_limit);
      REG_LOWER:      prdata = CFG_DATA_W'(cfg.lower_limit);
      REG_REVERSE:    prdata = CFG_DATA_W'(cfg.reverse_action);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== sv/ipidd_core.sv =====
module ipidd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  ipidd_pkg::cfg_t      cfg,
  input  logic                 step,
  input  ipidd_pkg::in_item_t  item,
  output ipidd_pkg::result_t   res
);
  import ipidd_pkg::*;

  // Controller state
  logic signed [ACC_W-1:0] accumulator, accumulator_next;
  logic signed [ERR_W-1:0] error_now, error_now_next;
  logic signed [ERR_W-1:0] error_prev, error_prev_next;
  logic signed [ERR_W-1:0] error_prev2, error_prev2_next;

  logic signed [ERR_W-1:0]   err_raw;
  logic signed [ERR_W-1:0]   err_dir;
  logic        [ERR_W-1:0]   err_mag;
  logic                      below_db;
  logic signed [PROD_W-1:0]  p0, p1, p2;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ACC_W-1:0]   sum_sat;
  logic signed [ACC_W-1:0]   upper_ext, lower_ext;
  logic signed [ACC_W-1:0]   clamped;

  // Error, direction and deadband test
  assign err_raw  = ERR_W'(item.setpoint) - ERR_W'(item.process_value);
  assign err_mag  = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
  assign below_db = err_mag < ERR_W'(cfg.deadband);
  assign err_dir  = cfg.reverse_action ? ERR_W'(-err_raw) : err_raw;

  // Three parallel products on the shifted history
  assign p0 = PROD_W'(cfg.coef_now)   * PROD_W'(err_dir);
  assign p1 = PROD_W'(cfg.coef_prev)  * PROD_W'(error_now);
  assign p2 = PROD_W'(cfg.coef_prev2) * PROD_W'(error_prev);

  // Accumulate and saturate
  assign sum = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + SUM_W'(accumulator);

  always_comb begin
    priority if (sum > SUM_W'(ACC_MAX)) begin
      sum_sat = ACC_MAX;
    end else if (sum < SUM_W'(ACC_MIN)) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
  end

  // State update
  always_comb begin
    accumulator_next = accumulator;
    error_now_next   = error_now;
    error_prev_next  = error_prev;
    error_prev2_next = error_prev2;
    if (item.command == CMD_CLEAR) begin
      accumulator_next = '0;
      error_now_next   = '0;
      error_prev_next  = '0;
      error_prev2_next = '0;
    end else if (!below_db) begin
      accumulator_next = sum_sat;
      error_now_next   = err_dir;
      error_prev_next  = error_now;
      error_prev2_next = error_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      error_now   <= '0;
      error_prev  <= '0;
      error_prev2 <= '0;
    end else if (step) begin
      accumulator <= accumulator_next;
      error_now   <= error_now_next;
      error_prev  <= error_prev_next;
      error_prev2 <= error_prev2_next;
    end
  end

  // Output clamp, upper test first
  assign upper_ext = ACC_W'(cfg.upper_limit);
  assign lower_ext = ACC_W'(cfg.lower_limit);

  always_comb begin
    priority if (accumulator_next > upper_ext) begin
      clamped = upper_ext;
    end else if (accumulator_next < lower_ext) begin
      clamped = lower_ext;
    end else begin
      clamped = accumulator_next;
    end
  end

  always_comb begin
    if (item.command == CMD_CLEAR) begin
      res.drive       = '0;
      res.in_deadband = 1'b0;
    end else begin
      res.drive       = clamped[LIMIT_W-1:0];
      res.in_deadband = below_db;
    end
  end

  // Checks
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    step && item.command == CMD_CLEAR |=> accumulator == '0 && error_now == '0
      && error_prev == '0 && error_prev2 == '0)
    else $error("clear did not zero the controller state");

  a_deadband_holds: assert property (@(posedge clk) disable iff (rst)
    step && item.command == CMD_SAMPLE && below_db |=>
      $stable(accumulator) && $stable(error_now) && $stable(error_prev))
    else $error("state changed inside the deadband");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(accumulator) && $stable(error_prev2))
    else $error("state changed without an item");

  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    step && item.command == CMD_SAMPLE && !below_db |=>
      error_prev == $past(error_now) && error_prev2 == $past(error_prev))
    else $error("error history did not shift");

endmodule

// ===== sv/incremental_pid_with_deadband_unit.sv =====
// Velocity-form PID controller with deadband. Each stream transaction carries a
// process value and a setpoint (tdata) and a command (tuser: 0 sample, 1 clear);
// each produces one result transaction with the Q16.16 drive clamped to the
// limit registers (tdata) and an in-deadband flag (tuser). The block takes one
// item per clock cycle while the result stream is not stalled; an accepted item
// waits in the input register, then passes the error/multiply/accumulate/clamp
// path into the output register. The accumulator loop - three 24x17 multiplies,
// a 50-bit sum and saturation - is combinational. Coefficients, deadband, limits
// and the action direction are written over the APB port; the user must do so
// only while the stream is idle, as the block itself does not enforce this.
module incremental_pid_with_deadband_unit (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipidd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ipidd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ipidd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready,
  // sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // [15:0] process_value, [31:16] setpoint
  input  logic [0:0]                        s_axis_tuser,  // [0] command
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // [31:0] drive
  output logic [0:0]                        m_axis_tuser   // [0] in_deadband
);
  import ipidd_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_valid;
  result_t  core_res;
  result_t  out_item;
  logic     out_valid;
  logic     out_free;
  logic     advance;
  logic     s_accept;

  ipidd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the output register frees when empty or drained this cycle
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.command       <= cmd_t'(s_axis_tuser[0]);
      in_item.process_value <= s_axis_tdata[SAMPLE_W-1:0];
      in_item.setpoint      <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  ipidd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (in_item),
    .res  (core_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_res;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_item.drive;
  assign m_axis_tuser[0] = out_item.in_deadband;

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |-> !advance)
    else $error("pending result overwritten");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("stalled input item lost");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item produced no result");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipidd_pkg::*;

  // Cycles with no transaction on any port before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    in_item_t item;
    bit       wait_drain;
  } sample_job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [15:0] process_value, [31:16] setpoint
  logic [0:0]  s_axis_tuser  = '0;  // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] drive
  logic [0:0]  m_axis_tuser;        // [0] in_deadband

  // Controller image: registers and loop state
  cfg_t                     pid_cfg   = '0;
  logic signed [ACC_W-1:0]  acc_q     = '0;
  logic signed [ERR_W-1:0]  err_now   = '0;
  logic signed [ERR_W-1:0]  err_prev  = '0;
  logic signed [ERR_W-1:0]  err_prev2 = '0;

  sample_job_t sample_jobs[$];
  result_t     drive_due[$];
  sample_job_t next_job;
  in_item_t    in_flight;
  result_t     got_due;

  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  wind_pct     = 23;
  bit  wind_down    = 1'b0;
  int  mismatches   = 0;
  int  n_accepted   = 0;
  int  n_results    = 0;
  int  n_clear      = 0;
  int  n_dead       = 0;
  int  n_sat        = 0;
  int  n_clamp      = 0;
  int  n_settings   = 0;
  int  stall_cycles = 0;

  incremental_pid_with_deadband_unit uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One controller step: updates the loop state and returns the expected result
  function automatic result_t pid_step(input in_item_t it);
    result_t r;
    longint  dev;
    longint  mag;
    longint  sum;
    r.drive       = '0;
    r.in_deadband = 1'b0;
    if (it.command == CMD_CLEAR) begin
      acc_q     = '0;
      err_now   = '0;
      err_prev  = '0;
      err_prev2 = '0;
      n_clear++;
      return r;
    end
    dev = longint'($signed(it.setpoint)) - longint'($signed(it.process_value));
    mag = (dev < 0) ? -dev : dev;
    if (mag < longint'(pid_cfg.deadband)) begin
      // state frozen, output still the clamped accumulator
      r.in_deadband = 1'b1;
      n_dead++;
    end else begin
      err_prev2 = err_prev;
      err_prev  = err_now;
      err_now   = ERR_W'(pid_cfg.reverse_action ? -dev : dev);
      sum = longint'($signed(pid_cfg.coef_now)) * longint'(err_now)
          + longint'($signed(pid_cfg.coef_prev)) * longint'(err_prev)
          + longint'($signed(pid_cfg.coef_prev2)) * longint'(err_prev2)
          + longint'(acc_q);
      if (sum > longint'(ACC_MAX)) begin
        sum = longint'(ACC_MAX);
        n_sat++;
      end else if (sum < longint'(ACC_MIN)) begin
        sum = longint'(ACC_MIN);
        n_sat++;
      end
      acc_q = ACC_W'(sum);
    end
    // upper bound wins when the limits are crossed
    if (longint'(acc_q) > longint'($signed(pid_cfg.upper_limit))) begin
      r.drive = pid_cfg.upper_limit;
      n_clamp++;
    end else if (longint'(acc_q) < longint'($signed(pid_cfg.lower_limit))) begin
      r.drive = pid_cfg.lower_limit;
      n_clamp++;
    end else begin
      r.drive = acc_q[LIMIT_W-1:0];
    end
    return r;
  endfunction

  function automatic int corner_sample();
    case ($urandom_range(4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // Random sample: full-range noise, deadband edges, wind-up runs, corners and clears
  function automatic in_item_t make_sample();
    in_item_t it;
    int       pick;
    int       e;
    int       lo;
    int       hi;
    int       pv;
    bit       by_error;
    it.command       = CMD_SAMPLE;
    it.process_value = SAMPLE_W'($urandom);
    it.setpoint      = SAMPLE_W'($urandom);
    by_error         = 1'b0;
    e                = 0;
    if ($urandom_range(119) == 0) wind_down = !wind_down;
    pick = $urandom_range(99);
    if (pick < 3) begin
      it.command = CMD_CLEAR;
    end else if (pick < 3 + wind_pct) begin
      // large error in one direction drives the accumulator toward saturation
      e = 40000 + int'($urandom_range(25535));
      if (wind_down) e = -e;
      by_error = 1'b1;
    end else begin
      pick = $urandom_range(9);
      if (pick >= 8) begin
        it.process_value = SAMPLE_W'(corner_sample());
        it.setpoint      = SAMPLE_W'(corner_sample());
      end else if (pick >= 5) begin
        // error magnitude within two of the deadband
        e = int'(pid_cfg.deadband) + int'($urandom_range(4)) - 2;
        if (e > 65535) e = 65535;
        if (e < 0) e = 0;
        if ($urandom_range(1) == 1) e = -e;
        by_error = 1'b1;
      end
    end
    if (by_error) begin
      lo = (e > 0) ? -32768 : -32768 - e;
      hi = (e > 0) ? 32767 - e : 32767;
      pv = lo + int'($urandom_range(hi - lo));
      it.process_value = SAMPLE_W'(pv);
      it.setpoint      = SAMPLE_W'(pv + e);
    end
    return it;
  endfunction

  function automatic cfg_t pick_setting(input int k);
    cfg_t c;
    c.coef_now       = COEF_W'($urandom);
    c.coef_prev      = COEF_W'($urandom);
    c.coef_prev2     = COEF_W'($urandom);
    c.deadband       = SAMPLE_W'($urandom_range(300));
    c.upper_limit    = LIMIT_W'($urandom);
    c.lower_limit    = LIMIT_W'($urandom);
    c.reverse_action = 1'($urandom_range(1));
    case (k)
      0: begin
        c.coef_now       = 24'h7FFFFF;
        c.coef_prev      = 24'h800000;
        c.coef_prev2     = 24'h010000;
        c.deadband       = 16'd100;
        c.upper_limit    = 32'h7FFFFFFF;
        c.lower_limit    = 32'h80000000;
        c.reverse_action = 1'b0;
      end
      1: begin
        c.coef_now       = 24'h7FFFFF;
        c.coef_prev      = 24'h7FFFFF;
        c.coef_prev2     = 24'h7FFFFF;
        c.deadband       = 16'd0;
        c.upper_limit    = 32'h7FFFFFFF;
        c.lower_limit    = 32'h80000000;
        c.reverse_action = 1'b1;
      end
      2: begin
        // most negative gains, widest deadband, crossed limits
        c.coef_now       = 24'h800000;
        c.coef_prev      = 24'h800000;
        c.coef_prev2     = 24'h800000;
        c.deadband       = 16'hFFFF;
        c.upper_limit    = 32'h80000000;
        c.lower_limit    = 32'h7FFFFFFF;
        c.reverse_action = 1'b0;
      end
      4: begin
        c.coef_now       = COEF_W'(int'($urandom_range(262143)) - 131072);
        c.coef_prev      = COEF_W'(int'($urandom_range(262143)) - 131072);
        c.coef_prev2     = COEF_W'(int'($urandom_range(262143)) - 131072);
        c.deadband       = SAMPLE_W'($urandom_range(20));
        c.upper_limit    = LIMIT_W'($urandom_range(32'h0400_0000));
        c.lower_limit    = LIMIT_W'(-int'($urandom_range(32'h0400_0000)));
        c.reverse_action = 1'b1;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COEF_NOW:   pid_cfg.coef_now       = value[COEF_W-1:0];
      REG_COEF_PREV:  pid_cfg.coef_prev      = value[COEF_W-1:0];
      REG_COEF_PREV2: pid_cfg.coef_prev2     = value[COEF_W-1:0];
      REG_DEADBAND:   pid_cfg.deadband       = value[SAMPLE_W-1:0];
      REG_UPPER:      pid_cfg.upper_limit    = value[LIMIT_W-1:0];
      REG_LOWER:      pid_cfg.lower_limit    = value[LIMIT_W-1:0];
      REG_REVERSE:    pid_cfg.reverse_action = value[0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(input cfg_t c);
    write_reg(REG_COEF_NOW, {8'h00, c.coef_now});
    write_reg(REG_COEF_PREV, {8'h00, c.coef_prev});
    write_reg(REG_COEF_PREV2, {8'h00, c.coef_prev2});
    write_reg(REG_DEADBAND, {16'h0000, c.deadband});
    write_reg(REG_UPPER, c.upper_limit);
    write_reg(REG_LOWER, c.lower_limit);
    write_reg(REG_REVERSE, {31'd0, c.reverse_action});
    n_settings++;
  endtask

  task automatic queue_item(input cmd_t cmd, input int pv, input int sp, input bit hold);
    sample_job_t job;
    job.item.command       = cmd;
    job.item.process_value = SAMPLE_W'(pv);
    job.item.setpoint      = SAMPLE_W'(sp);
    job.wait_drain         = hold;
    sample_jobs.push_back(job);
  endtask

  task automatic fill_random(input int count);
    sample_job_t job;
    for (int i = 0; i < count; i++) begin
      job.item       = make_sample();
      job.wait_drain = ($urandom_range(99) == 0);
      sample_jobs.push_back(job);
    end
  endtask

  // Checked away from the rising edge so the driver's updates have settled
  task automatic wait_drained();
    while (sample_jobs.size() != 0 || s_axis_tvalid || drive_due.size() != 0)
      @(negedge clk);
  endtask

  // Sample stream driver; the expectation is formed when the transaction is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        drive_due.push_back(pid_step(in_flight));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_jobs.size() != 0
            && !(sample_jobs[0].wait_drain && drive_due.size() != 0)
            && $urandom_range(99) >= src_idle_pct) begin
          next_job      = sample_jobs.pop_front();
          in_flight     = next_job.item;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {next_job.item.setpoint, next_job.item.process_value};
          s_axis_tuser  <= next_job.item.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (drive_due.size() == 0) begin
          $error("result transaction with nothing expected: drive %0d in_deadband %0b",
                 $signed(m_axis_tdata), m_axis_tuser[0]);
          mismatches++;
        end else begin
          got_due = drive_due.pop_front();
          if (m_axis_tdata !== got_due.drive) begin
            $error("drive: expected %0d, got %0d", $signed(got_due.drive),
                   $signed(m_axis_tdata));
            mismatches++;
          end
          if (m_axis_tuser[0] !== got_due.in_deadband) begin
            $error("in_deadband: expected %0b, got %0b", got_due.in_deadband,
                   m_axis_tuser[0]);
            mismatches++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (psel && penable && pwrite))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("no transaction for %0d cycles, %0d results outstanding", STALL_LIMIT,
             drive_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values: zero gains and limits
    src_idle_pct = 13;
    snk_idle_pct = 69;
    queue_item(CMD_SAMPLE, 300, -200, 1'b0);
    queue_item(CMD_CLEAR, -5, 7, 1'b0);
    queue_item(CMD_SAMPLE, -32768, 32767, 1'b0);
    wait_drained();

    // Directed: error extremes, deadband edges, clears, wind-up
    apply_setting(pick_setting(0));
    queue_item(CMD_CLEAR, 0, 0, 1'b0);
    queue_item(CMD_SAMPLE, -32768, 32767, 1'b0);
    queue_item(CMD_SAMPLE, 32767, -32768, 1'b0);
    queue_item(CMD_SAMPLE, 0, 0, 1'b0);
    queue_item(CMD_SAMPLE, 0, 99, 1'b0);
    queue_item(CMD_SAMPLE, 0, 100, 1'b0);
    queue_item(CMD_SAMPLE, 100, 0, 1'b0);
    queue_item(CMD_SAMPLE, -99, 0, 1'b0);
    queue_item(CMD_CLEAR, 1234, -4321, 1'b0);
    queue_item(CMD_SAMPLE, -1, -1, 1'b0);
    for (int i = 0; i < 6; i++) queue_item(CMD_SAMPLE, -32768, 32767, 1'b0);
    for (int i = 0; i < 4; i++) queue_item(CMD_SAMPLE, 32767, -32768, 1'b0);
    queue_item(CMD_CLEAR, 32767, 32767, 1'b1);
    queue_item(CMD_SAMPLE, 32767, 32767, 1'b0);
    wait_drained();
    fill_random(280);
    wait_drained();

    // Random phases over several register settings and idle profiles
    for (int k = 1; k < 6; k++) begin
      if (k == 2) begin
        src_idle_pct = 69;
        snk_idle_pct = 13;
      end else if (k == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      wind_pct = (k == 1) ? 70 : 23;
      apply_setting(pick_setting(k));
      fill_random(k == 2 ? 120 : (k == 3 ? 400 : 300));
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d samples (%0d clears, %0d inside deadband) across %0d settings.",
             n_accepted, n_clear, n_dead, n_settings);
    $display("Checked %0d results; accumulator saturated %0d times, output clamped %0d times.",
             n_results, n_sat, n_clamp);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
